### rtl/core/wasm_pkg.sv
// ----------------------------------------------------------------------------
// wasm_pkg
// shared constants, types and character helpers for the anchored
// wildcard substring matcher
// ----------------------------------------------------------------------------
package wasm_pkg;

    localparam int PATTERN_MAX = 256;
    localparam int CNT_W       = $clog2(PATTERN_MAX + 1);

    localparam logic [7:0] CH_DOT    = 8'd46;  // '.'
    localparam logic [7:0] CH_CARET  = 8'd94;  // '^'
    localparam logic [7:0] CH_DOLLAR = 8'd36;  // '$'
    localparam logic [7:0] UPPER_LO  = 8'd65;
    localparam logic [7:0] UPPER_HI  = 8'd90;
    localparam logic [7:0] CASE_OFS  = 8'd32;

    // broadcast control for the cell row
    typedef struct packed {
        logic shift;         // load beat: characters move one cell up
        logic restart;       // load beat that opens a new pattern
        logic step;          // subject beat against a loaded pattern
        logic clear;         // drop all active bits
        logic start_anchor;  // loaded pattern begins with an anchor
        logic first;         // no subject character seen yet
    } t_chain_ctrl;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= UPPER_LO && c <= UPPER_HI) begin
            r = c + CASE_OFS;
        end
        return r;
    endfunction

    function automatic logic char_match(input logic [7:0] pat, input logic [7:0] sub);
        return (pat == CH_DOT) || (fold_case(pat) == fold_case(sub));
    endfunction

endpackage

### rtl/core/wasm_cell.sv
// ----------------------------------------------------------------------------
// wasm_cell
// one pattern position: stored character, valid bit and active bit
// ----------------------------------------------------------------------------
module wasm_cell
    import wasm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chain_ctrl i_ctrl,
    input  logic [7:0]  i_sub_ch,
    input  logic [7:0]  i_up_ch,
    input  logic        i_up_valid,
    input  logic        i_dn_valid,
    input  logic        i_link_in,
    output logic [7:0]  o_ch,
    output logic        o_valid,
    output logic        o_link,
    output logic        o_step_act
);

    logic [7:0] r_ch;
    logic       r_valid;
    logic       r_act;
    logic       n_act;
    logic       w_anchor;

    // topmost loaded cell holds the leading anchor when there is one
    assign w_anchor   = r_valid && !i_dn_valid && i_ctrl.start_anchor;
    assign o_link     = !r_valid ? 1'b1 : (w_anchor ? i_ctrl.first : r_act);
    assign o_step_act = r_valid && !w_anchor && i_link_in && char_match(r_ch, i_sub_ch);
    assign o_ch       = r_ch;
    assign o_valid    = r_valid;

    always_comb begin
        n_act = r_act;
        if (i_ctrl.clear) begin
            n_act = 1'b0;
        end else if (i_ctrl.step) begin
            n_act = o_step_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_act   <= 1'b0;
        end else begin
            r_act <= n_act;
            if (i_ctrl.shift) begin
                r_valid <= i_up_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_ch <= i_up_ch;
        end
    end

endmodule

### rtl/core/wasm_chain.sv
// ----------------------------------------------------------------------------
// wasm_chain
// row of pattern cells; characters enter at cell 0 and move up, match
// state moves down from the first pattern character towards cell 0
// ----------------------------------------------------------------------------
module wasm_chain
    import wasm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chain_ctrl i_ctrl,
    input  logic [7:0]  i_ch,
    output logic [7:0]  o_cell0_ch,
    output logic        o_step_act0,
    output logic        o_step_act1
);

    logic [7:0] w_ch    [PATTERN_MAX];
    logic       w_valid [PATTERN_MAX];
    logic       w_link  [PATTERN_MAX];
    logic       w_step  [PATTERN_MAX];

    genvar j;
    generate
        for (j = 0; j < PATTERN_MAX; j++) begin : g_cell
            logic [7:0] w_up_ch;
            logic       w_up_valid;
            logic       w_dn_valid;
            logic       w_link_in;

            if (j == 0) begin : g_head
                assign w_up_ch    = i_ch;
                assign w_up_valid = 1'b1;
            end else begin : g_body
                assign w_up_ch    = w_ch[j-1];
                assign w_up_valid = i_ctrl.restart ? 1'b0 : w_valid[j-1];
            end

            if (j == PATTERN_MAX - 1) begin : g_end
                assign w_dn_valid = 1'b0;
                assign w_link_in  = 1'b1;
            end else begin : g_mid
                assign w_dn_valid = w_valid[j+1];
                assign w_link_in  = w_link[j+1];
            end

            wasm_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (i_ctrl),
                .i_sub_ch   (i_ch),
                .i_up_ch    (w_up_ch),
                .i_up_valid (w_up_valid),
                .i_dn_valid (w_dn_valid),
                .i_link_in  (w_link_in),
                .o_ch       (w_ch[j]),
                .o_valid    (w_valid[j]),
                .o_link     (w_link[j]),
                .o_step_act (w_step[j])
            );
        end
    endgenerate

    assign o_cell0_ch  = w_ch[0];
    assign o_step_act0 = w_step[0];
    assign o_step_act1 = w_step[1];

endmodule

### rtl/core/wildcard_anchored_substring_match_core.sv
// result: the flag for a subject appears on o_valid in the cycle after its last beat
// throughput: one beat (pattern or subject character) per cycle while o_stall is low, set by the cell
//   row, which updates every pattern position in the same cycle
// pattern beats never produce an output beat
// reset (i_rst_n low, synchronous) drops the pattern, the subject and any output
// ----------------------------------------------------------------------------
// wildcard_anchored_substring_match_core
// loads a pattern with optional start and end anchors, then searches each
// subject for the pattern core, with '.' as wildcard and letters case folded
// ----------------------------------------------------------------------------
module wildcard_anchored_substring_match_core
    import wasm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_mode,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_matched
);

    // pattern load state
    logic [CNT_W-1:0] r_count;       // characters stored in the current load
    logic             r_done;        // complete pattern present
    logic             r_head_caret;  // first stored character is a caret
    logic             r_start_anchor;
    logic             r_end_anchor;
    logic             r_len_zero;    // pattern core is empty

    // subject state
    logic             r_first;       // no subject character seen yet
    logic             r_found;       // core seen somewhere in this subject

    // output register
    logic             r_ov;
    logic             r_om;

    logic             w_acc;
    logic             w_load;
    logic             w_sub;
    logic [CNT_W-1:0] w_base;
    logic             w_room;
    logic [CNT_W-1:0] n_count;
    logic             w_s;
    logic             w_e;
    logic [CNT_W-1:0] w_trim;
    logic             w_len_zero;
    logic [7:0]       w_cell0_ch;
    logic             w_act0;
    logic             w_act1;
    logic             w_hit;
    logic             n_found;
    logic             w_match;
    t_chain_ctrl      w_ctrl;

    // input beat taken whenever the output slot is free or draining this cycle
    assign o_stall = r_ov && i_stall;
    assign w_acc   = i_valid && !o_stall;
    assign w_load  = w_acc && !i_mode;
    assign w_sub   = w_acc && i_mode;

    // a load beat after a complete pattern starts over from an empty store
    assign w_base  = r_done ? '0 : r_count;
    assign w_room  = w_base < CNT_W'(PATTERN_MAX);
    assign n_count = w_room ? w_base + 1'b1 : w_base;

    // anchors judged on the stored characters; the last stored one is the
    // incoming character unless the store is already full
    assign w_s = (w_base == '0) ? (i_ch == CH_CARET) : r_head_caret;
    assign w_e = (n_count > CNT_W'(w_s))
              && (w_room ? (i_ch == CH_DOLLAR) : (w_cell0_ch == CH_DOLLAR));
    assign w_trim     = CNT_W'(w_s) + CNT_W'(w_e);
    assign w_len_zero = (n_count == w_trim);

    always_comb begin
        w_ctrl.shift        = w_load && w_room;
        w_ctrl.restart      = w_load && r_done;
        w_ctrl.step         = w_sub && r_done;
        w_ctrl.clear        = w_load || (w_sub && i_last);
        w_ctrl.start_anchor = r_start_anchor;
        w_ctrl.first        = r_first;
    end

    wasm_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_ch        (i_ch),
        .o_cell0_ch  (w_cell0_ch),
        .o_step_act0 (w_act0),
        .o_step_act1 (w_act1)
    );

    // the last core position sits in cell 1 when a trailing anchor holds cell 0
    assign w_hit   = r_end_anchor ? w_act1 : w_act0;
    assign n_found = r_found || (!r_len_zero && !r_end_anchor && w_hit);

    always_comb begin
        if (!r_done) begin
            w_match = 1'b0;
        end else if (r_len_zero) begin
            w_match = 1'b1;
        end else if (r_end_anchor) begin
            w_match = w_hit;
        end else begin
            w_match = n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count        <= '0;
            r_done         <= 1'b0;
            r_head_caret   <= 1'b0;
            r_start_anchor <= 1'b0;
            r_end_anchor   <= 1'b0;
            r_len_zero     <= 1'b0;
            r_first        <= 1'b1;
            r_found        <= 1'b0;
            r_ov           <= 1'b0;
        end else begin
            if (w_load) begin
                r_count <= n_count;
                r_done  <= i_last;
                if (w_base == '0) begin
                    r_head_caret <= (i_ch == CH_CARET);
                end
                if (i_last) begin
                    r_start_anchor <= w_s;
                    r_end_anchor   <= w_e;
                    r_len_zero     <= w_len_zero;
                end else if (r_done) begin
                    r_start_anchor <= 1'b0;
                    r_end_anchor   <= 1'b0;
                end
            end

            // subject bookkeeping, cleared on every load beat and subject end
            if (w_load || (w_sub && i_last)) begin
                r_first <= 1'b1;
                r_found <= 1'b0;
            end else if (w_ctrl.step) begin
                r_first <= 1'b0;
                r_found <= n_found;
            end

            if (w_sub && i_last) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sub && i_last) begin
            r_om <= w_match;
        end
    end

    assign o_valid   = r_ov;
    assign o_matched = r_om;

    // a subject end always leaves a result beat behind
    a_end_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sub && i_last) |=> o_valid)
        else $error("no result beat after subject end");

    // no pattern loaded means no match
    a_no_pattern_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sub && i_last && !r_done) |=> !o_matched)
        else $error("match reported without a pattern");

    // an empty core matches every subject
    a_empty_core_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sub && i_last && r_done && r_len_zero) |=> o_matched)
        else $error("empty core did not match");

    // final pattern beat completes the load with the stored count in range
    a_load_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && i_last) |=> (r_done && r_count != '0
                                && r_count <= CNT_W'(PATTERN_MAX)))
        else $error("pattern load did not complete");

    // the found flag only rises on a subject step
    a_found_on_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_found) |-> $past(w_ctrl.step))
        else $error("found flag set outside a subject step");

endmodule
